// ===== src/ldf_pkg.sv =====
`default_nettype none

package ldf_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned RoleW    = 3;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  localparam logic [ByteW-1:0] XorKey = 8'h31;
  localparam logic [ByteW-1:0] SumOk  = 8'h00;

  // register index taken from paddr[2] (word aligned)
  localparam logic RegDecodeEnable = 1'b0;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_LEN  = 3'd2,
    PH_EXTH = 3'd3,
    PH_EXTL = 3'd4,
    PH_PAY  = 3'd5,
    PH_CSUM = 3'd6
  } phase_e;

  typedef enum logic [RoleW-1:0] {
    ROLE_HDR  = 3'd0,
    ROLE_LEN  = 3'd1,
    ROLE_EXTH = 3'd2,
    ROLE_EXTL = 3'd3,
    ROLE_PAY  = 3'd4,
    ROLE_CSUM = 3'd5
  } role_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    role_e            byte_role;
    logic             frame_end;
    logic             checksum_bad;
  } parse_res_t;

endpackage

`default_nettype wire

// ===== src/ldf_if.sv =====
`default_nettype none

interface ldf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ldf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] byte_role;
  logic       frame_end;
  logic       checksum_bad;

  modport source (output valid, output out_byte, output byte_role, output frame_end,
                  output checksum_bad, input ready);
  modport sink   (input valid, input out_byte, input byte_role, input frame_end,
                  input checksum_bad, output ready);
endinterface

`default_nettype wire

// ===== src/ldf_apb_regs.sv =====
`default_nettype none

module ldf_apb_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ldf_pkg::PaddrW-1:0]  paddr,
  input  wire logic [ldf_pkg::PdataW-1:0]  pwdata,
  output logic      [ldf_pkg::PdataW-1:0]  prdata,
  output logic                             pready,
  output logic                             decode_en_o
);

  logic decode_en_q;
  logic decode_en_d;
  logic wr_en;
  logic sel_decode;

  assign pready     = 1'b1;
  assign sel_decode = (paddr[ldf_pkg::PaddrW-1] == ldf_pkg::RegDecodeEnable);
  assign wr_en      = psel && penable && pwrite && pready;

  always_comb begin
    decode_en_d = decode_en_q;
    if (wr_en && sel_decode) begin
      decode_en_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_en_q <= 1'b0;
    end else begin
      decode_en_q <= decode_en_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_decode) begin
      prdata[0] = decode_en_q;
    end
  end

  assign decode_en_o = decode_en_q;

endmodule

`default_nettype wire

// ===== src/ldf_parse_core.sv =====
`default_nettype none

module ldf_parse_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [ldf_pkg::ByteW-1:0]   raw_byte_i,
  input  wire logic                        decode_en_i,
  output ldf_pkg::parse_res_t              res_o
);

  ldf_pkg::phase_e               phase_q, phase_d;
  logic [ldf_pkg::LenW-1:0]      bytes_left_q, bytes_left_d;
  logic [ldf_pkg::ByteW-1:0]     sum_q, sum_d;
  logic [ldf_pkg::ByteW-1:0]     len_hi_q, len_hi_d;

  logic [ldf_pkg::ByteW-1:0]     dec_byte;
  logic [ldf_pkg::ByteW-1:0]     sum_add;
  logic [ldf_pkg::LenW-1:0]      left_dec;
  logic [ldf_pkg::LenW-1:0]      ext_len;

  assign dec_byte = decode_en_i ? (raw_byte_i ^ ldf_pkg::XorKey) : raw_byte_i;
  assign sum_add  = sum_q + dec_byte;
  assign left_dec = bytes_left_q - {{(ldf_pkg::LenW-1){1'b0}}, 1'b1};
  assign ext_len  = {len_hi_q, dec_byte};

  // next state
  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    sum_d        = sum_q;
    len_hi_d     = len_hi_q;
    unique case (phase_q)
      ldf_pkg::PH_HDR1: begin
        sum_d   = '0;
        phase_d = ldf_pkg::PH_LEN;
      end
      ldf_pkg::PH_LEN: begin
        sum_d = dec_byte;
        if (dec_byte == '0) begin
          phase_d = ldf_pkg::PH_EXTH;
        end else begin
          bytes_left_d = {{(ldf_pkg::LenW-ldf_pkg::ByteW){1'b0}}, dec_byte};
          phase_d      = ldf_pkg::PH_PAY;
        end
      end
      ldf_pkg::PH_EXTH: begin
        sum_d    = sum_add;
        len_hi_d = dec_byte;
        phase_d  = ldf_pkg::PH_EXTL;
      end
      ldf_pkg::PH_EXTL: begin
        sum_d        = sum_add;
        bytes_left_d = ext_len;
        phase_d      = (ext_len == '0) ? ldf_pkg::PH_CSUM : ldf_pkg::PH_PAY;
      end
      ldf_pkg::PH_PAY: begin
        sum_d        = sum_add;
        bytes_left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = ldf_pkg::PH_CSUM;
        end
      end
      ldf_pkg::PH_CSUM: begin
        sum_d        = '0;
        bytes_left_d = '0;
        phase_d      = ldf_pkg::PH_HDR0;
      end
      default: begin
        sum_d   = '0;
        phase_d = ldf_pkg::PH_HDR1;
      end
    endcase
  end

  // result fields
  always_comb begin
    res_o.out_byte     = dec_byte;
    res_o.frame_end    = 1'b0;
    res_o.checksum_bad = 1'b0;
    unique case (phase_q)
      ldf_pkg::PH_LEN:  res_o.byte_role = ldf_pkg::ROLE_LEN;
      ldf_pkg::PH_EXTH: res_o.byte_role = ldf_pkg::ROLE_EXTH;
      ldf_pkg::PH_EXTL: res_o.byte_role = ldf_pkg::ROLE_EXTL;
      ldf_pkg::PH_PAY:  res_o.byte_role = ldf_pkg::ROLE_PAY;
      ldf_pkg::PH_CSUM: begin
        res_o.byte_role    = ldf_pkg::ROLE_CSUM;
        res_o.frame_end    = 1'b1;
        res_o.checksum_bad = (sum_add != ldf_pkg::SumOk);
      end
      default:          res_o.byte_role = ldf_pkg::ROLE_HDR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= ldf_pkg::PH_HDR0;
      bytes_left_q <= '0;
      sum_q        <= '0;
      len_hi_q     <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      sum_q        <= sum_d;
      len_hi_q     <= len_hi_d;
    end
  end

  // a payload phase always has bytes outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ldf_pkg::PH_PAY |-> bytes_left_q != '0)
    else $error("payload phase with zero bytes left");

  // closing a frame clears the parse context
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == ldf_pkg::PH_CSUM
    |=> phase_q == ldf_pkg::PH_HDR0 && sum_q == '0 && bytes_left_q == '0)
    else $error("frame close did not reset parse context");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == ldf_pkg::PH_HDR1 |=> phase_q == ldf_pkg::PH_LEN)
    else $error("second header byte not followed by length phase");

endmodule

`default_nettype wire

// ===== src/length_framed_packet_deframer.sv =====
`default_nettype none

// channel   | dir | payload                                          | handshake
// in_ch_i   | in  | rx_byte[7:0]                                     | valid/ready
// out_ch_o  | out | out_byte[7:0] byte_role[2:0] frame_end checksum_bad | valid/ready
// apb       | in  | paddr[2:0] pwdata[31:0] / prdata[31:0]          | psel/penable
//
// one request per cycle sustained while out ready stays high; a request passes the input
// register, parse logic and result register before its result is offered.
// rst_ni clears the parse phase, byte count, running sum and decode_enable.
// a stalled result holds the result register; the input register takes one more request
// only if it is empty, and in ready then stays low until the parser can advance.

module length_framed_packet_deframer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  ldf_in_if.sink                           in_ch_i,
  ldf_out_if.source                        out_ch_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ldf_pkg::PaddrW-1:0]  paddr,
  input  wire logic [ldf_pkg::PdataW-1:0]  pwdata,
  output logic      [ldf_pkg::PdataW-1:0]  prdata,
  output logic                             pready
);

  logic                      decode_en;
  logic                      in_valid_q;
  logic [ldf_pkg::ByteW-1:0] in_byte_q;
  logic                      out_valid_q;
  ldf_pkg::parse_res_t       res_q;
  ldf_pkg::parse_res_t       res;
  logic                      advance;
  logic                      in_ready;

  ldf_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .decode_en_o (decode_en)
  );

  assign advance  = in_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign in_ch_i.ready = in_ready;

  ldf_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .raw_byte_i  (in_byte_q),
    .decode_en_i (decode_en),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_ch_i.valid) begin
      in_byte_q <= in_ch_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.out_byte     = res_q.out_byte;
  assign out_ch_o.byte_role    = res_q.byte_role;
  assign out_ch_o.frame_end    = res_q.frame_end;
  assign out_ch_o.checksum_bad = res_q.checksum_bad;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_end |-> res_q.byte_role == ldf_pkg::ROLE_CSUM)
    else $error("frame end on a non-checksum byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.checksum_bad |-> res_q.frame_end)
    else $error("checksum error flagged outside frame end");

  // a held result must keep the parser from advancing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch_o.ready |-> !advance)
    else $error("parser advanced over a stalled result");

endmodule

`default_nettype wire
